// ===== rtl/core/gisp_pkg.sv =====
// Shared constants, status codes and the front-to-back command type.
package gisp_pkg;

	localparam int GROUP_W  = 6;
	localparam int COUNT_W  = 16;
	localparam int STATUS_W = 3;

	localparam logic [COUNT_W-1:0] CHILD_LIMIT = 16'hFFFF;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic OP_CHILD  = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_MISSING  = 3'd1,
		ST_UNSORTED = 3'd2,
		ST_RANGE    = 3'd3,
		ST_TOOMANY  = 3'd4
	} status_t;

	// One item's worth of results: optional leading zero, a run of equal
	// offsets, then an optional error result.
	typedef struct packed {
		logic                 lead;
		logic [GROUP_W-1:0]   run_len;
		logic [COUNT_W-1:0]   run_val;
		status_t              status;
		logic                 array_end;
	} cmd_t;

endpackage

// ===== rtl/core/gisp_item_if.sv =====
// Input channel: child entries and finish items.
interface gisp_item_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [gisp_pkg::GROUP_W-1:0] group_id;
	logic                         present;

	modport source(output valid, operation, group_id, present, input ready);
	modport sink(input valid, operation, group_id, present, output ready);
endinterface

// ===== rtl/core/gisp_result_if.sv =====
// Output channel: split points and status.
interface gisp_result_if;
	logic                          valid;
	logic                          ready;
	logic [gisp_pkg::COUNT_W-1:0]  split_point;
	logic [gisp_pkg::STATUS_W-1:0] status;
	logic                          run_last;
	logic                          array_end;

	modport source(output valid, split_point, status, run_last, array_end, input ready);
	modport sink(input valid, split_point, status, run_last, array_end, output ready);
endinterface

// ===== rtl/core/gisp_front.sv =====
// Front end: takes items, tracks array state and classifies each item into a command.
module gisp_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gisp_pkg::GROUP_W-1:0] cfg_data,
	gisp_item_if.sink                    item,
	output gisp_pkg::cmd_t               cmd,
	output logic                         cmd_push,
	input  logic                         cmd_full
);
	import gisp_pkg::*;

	logic [GROUP_W-1:0] group_count_q;
	logic [GROUP_W-1:0] cur_bin_q;
	logic [COUNT_W-1:0] child_cnt_q;
	logic               started_q;
	logic               failed_q;

	logic    accept;
	logic    finish;
	status_t err;

	assign item.ready = !cmd_full;
	assign accept     = item.valid && item.ready;
	assign finish     = (item.operation == OP_FINISH);

	always_comb begin
		if (!item.present)
			err = ST_MISSING;
		else if (item.group_id >= group_count_q)
			err = ST_RANGE;
		else if (item.group_id < cur_bin_q)
			err = ST_UNSORTED;
		else if (child_cnt_q >= CHILD_LIMIT)
			err = ST_TOOMANY;
		else
			err = ST_OK;
	end

	always_comb begin
		cmd.lead      = !started_q;
		cmd.run_val   = child_cnt_q;
		cmd.array_end = finish;
		if (finish) begin
			// no bin left to fill after the leading offset went out earlier
			if (started_q && cur_bin_q >= group_count_q) begin
				cmd.run_len = '0;
				cmd.status  = ST_RANGE;
			end else begin
				cmd.run_len = group_count_q - cur_bin_q;
				cmd.status  = ST_OK;
			end
		end else begin
			cmd.status  = err;
			cmd.run_len = (err == ST_OK) ? item.group_id - cur_bin_q : '0;
		end
	end

	assign cmd_push = accept && !failed_q &&
		(finish || cmd.lead || cmd.status != ST_OK || cmd.run_len != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_count_q <= '0;
			cur_bin_q     <= '0;
			child_cnt_q   <= '0;
			started_q     <= 1'b0;
			failed_q      <= 1'b0;
		end else begin
			if (cfg_we)
				group_count_q <= cfg_data;
			if (accept) begin
				if (finish) begin
					cur_bin_q   <= '0;
					child_cnt_q <= '0;
					started_q   <= 1'b0;
					failed_q    <= 1'b0;
				end else if (!failed_q) begin
					started_q <= 1'b1;
					if (err != ST_OK) begin
						failed_q <= 1'b1;
					end else begin
						cur_bin_q   <= item.group_id;
						child_cnt_q <= child_cnt_q + 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== rtl/core/gisp_queue.sv =====
// Short command queue between front and back.
module gisp_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gisp_pkg::cmd_t push_data,
	output logic           full,
	input  logic           pop,
	output gisp_pkg::cmd_t pop_data,
	output logic           not_empty
);
	import gisp_pkg::*;

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wptr_q;
	logic [QPTR_W-1:0] rptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full      = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			if (pop)
				rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ===== rtl/core/gisp_back.sv =====
// Back end: expands one command into result transfers through an output register.
module gisp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  gisp_pkg::cmd_t cmd,
	input  logic           cmd_valid,
	output logic           cmd_pop,
	gisp_result_if.source  result
);
	import gisp_pkg::*;

	logic               active_q;
	logic               lead_q;
	logic [GROUP_W-1:0] cnt_q;
	logic [COUNT_W-1:0] val_q;
	status_t            st_q;
	logic               end_q;

	logic               out_valid_q;
	logic [COUNT_W-1:0] out_sp_q;
	status_t            out_st_q;
	logic               out_last_q;
	logic               out_end_q;

	logic               out_free;
	logic               emit;
	logic               last;
	logic [COUNT_W-1:0] res_sp;
	status_t            res_st;

	assign out_free = !out_valid_q || result.ready;
	assign emit     = active_q && out_free;
	assign cmd_pop  = cmd_valid && !active_q;

	always_comb begin
		if (lead_q) begin
			res_sp = '0;
			res_st = ST_OK;
			last   = (cnt_q == '0) && (st_q == ST_OK);
		end else if (cnt_q != '0) begin
			res_sp = val_q;
			res_st = ST_OK;
			last   = (cnt_q == GROUP_W'(1)) && (st_q == ST_OK);
		end else begin
			res_sp = '0;
			res_st = st_q;
			last   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			lead_q      <= 1'b0;
			cnt_q       <= '0;
			val_q       <= '0;
			st_q        <= ST_OK;
			end_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_sp_q    <= '0;
			out_st_q    <= ST_OK;
			out_last_q  <= 1'b0;
			out_end_q   <= 1'b0;
		end else begin
			if (cmd_pop) begin
				active_q <= 1'b1;
				lead_q   <= cmd.lead;
				cnt_q    <= cmd.run_len;
				val_q    <= cmd.run_val;
				st_q     <= cmd.status;
				end_q    <= cmd.array_end;
			end else if (emit) begin
				if (lead_q)
					lead_q <= 1'b0;
				else if (cnt_q != '0)
					cnt_q <= cnt_q - 1'b1;
				if (last)
					active_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
				out_sp_q    <= res_sp;
				out_st_q    <= res_st;
				out_last_q  <= last;
				out_end_q   <= last && end_q;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.split_point = out_sp_q;
	assign result.status      = out_st_q;
	assign result.run_last    = out_last_q;
	assign result.array_end   = out_end_q;

	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_end_q |-> out_last_q)
		else $error("array_end without run_last");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_st_q != ST_OK |-> out_sp_q == '0 && out_last_q)
		else $error("error result with offset or not last");

	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |=> active_q)
		else $error("loaded command not active");

	a_err_tail: assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !lead_q && cnt_q == '0 |-> st_q != ST_OK)
		else $error("empty command still active");

endmodule

// ===== rtl/core/group_ids_to_split_points.sv =====
// Top level: sorted group ids in, CSR-style split points out.
//
// item channel: child entries (operation 0: group_id, present) and finish
// items (operation 1). result channel: split_point, status, run_last and
// array_end per transfer. cfg_we/cfg_data write group_count; write it only
// while the block is idle.
// The front end classifies an item in the cycle it is accepted and pushes one
// command into a two-entry queue; items that cause no result push nothing.
// The back end loads a command once it is idle and issues one result per
// cycle into the output register while that register is free; it takes no new
// command until the last result of the current one is issued. The input
// stalls only when the queue is full.
// If the receiver stalls, the output register holds its result and the back
// end waits; the front keeps taking items until the queue fills.
// Reset clears group_count, the array state, the queue and the output valid.
module group_ids_to_split_points (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [gisp_pkg::GROUP_W-1:0] cfg_data,
	gisp_item_if.sink                    item,
	gisp_result_if.source                result
);
	import gisp_pkg::*;

	cmd_t cmd_in;
	cmd_t cmd_out;
	logic cmd_push;
	logic cmd_full;
	logic cmd_pop;
	logic cmd_valid;

	gisp_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.item     (item),
		.cmd      (cmd_in),
		.cmd_push (cmd_push),
		.cmd_full (cmd_full)
	);

	gisp_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd_in),
		.full      (cmd_full),
		.pop       (cmd_pop),
		.pop_data  (cmd_out),
		.not_empty (cmd_valid)
	);

	gisp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (cmd_valid),
		.cmd_pop   (cmd_pop),
		.result    (result)
	);

endmodule
